// File: rtl/dbsu_pkg.sv
`timescale 1ns / 1ps

package dbsu_pkg;

    // Table sizes.
    localparam int NUM_BREAKPOINTS = 8;
    localparam int NUM_TEMP_MARKS  = 4;
    localparam int BP_IDX_W  = (NUM_BREAKPOINTS > 1) ? $clog2(NUM_BREAKPOINTS) : 1;
    localparam int TMP_IDX_W = (NUM_TEMP_MARKS > 1) ? $clog2(NUM_TEMP_MARKS) : 1;

    // Field widths.
    localparam int ADDR_W   = 64;
    localparam int OPCODE_W = 8;
    localparam int CFG_W    = 8;

    // Length of one instruction, used for the step-over target.
    localparam logic [ADDR_W-1:0] INSTR_LEN = ADDR_W'(4);

    // Command codes.
    typedef enum logic [3:0] {
        CMD_RUN          = 4'd0,
        CMD_SINGLE_STEP  = 4'd1,
        CMD_STEP_OVER    = 4'd2,
        CMD_CONTINUE     = 4'd3,
        CMD_STOP         = 4'd4,
        CMD_ADD_BP       = 4'd5,
        CMD_REMOVE_BP    = 4'd6,
        CMD_TOGGLE_BP    = 4'd7,
        CMD_INTERCEPT    = 4'd8,
        CMD_PROCESS_EXIT = 4'd9
    } t_cmd;

    // Debug modes.
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STARTED = 3'd1,
        MODE_SINGLE  = 3'd2,
        MODE_RUNNING = 3'd3,
        MODE_WAITING = 3'd4
    } t_mode;

    // Status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_CALL_OPCODE     = 1'b0,
        CFG_CALL_IND_OPCODE = 1'b1
    } t_cfg_idx;

endpackage

// File: rtl/debug_breakpoint_step_unit_top.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle; busy is low whenever reset is released.
// The input register captures the request; the table compares and state update
// then run from it and load the result register.
// Reset is synchronous and active low; it clears the mode, both valid tables and
// the configuration registers. The receiver cannot stall the result strobe.
module debug_breakpoint_step_unit_top
    import dbsu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic [3:0]          i_cmd,
    input  logic [ADDR_W-1:0]   i_address,
    input  logic [OPCODE_W-1:0] i_opcode,
    output logic                o_done,
    output logic [1:0]          o_status,
    output logic                o_halt,
    output logic                o_start_machine,
    output logic                o_exit_request,
    output logic                o_release_res,
    output logic                o_breakpoint_hit,
    output logic [2:0]          o_debug_mode,
    output logic                o_process_exited
);

    // Input register.
    logic                r_in_vld;
    logic [3:0]          r_cmd;
    logic [ADDR_W-1:0]   r_addr;
    logic [OPCODE_W-1:0] r_opc;

    // Configuration.
    logic [OPCODE_W-1:0] r_call_opc;
    logic [OPCODE_W-1:0] r_call_ind_opc;

    // Debug state.
    t_mode                  r_mode;
    logic [NUM_BREAKPOINTS-1:0] r_bp_valid;
    logic [ADDR_W-1:0]      r_bp_addr [NUM_BREAKPOINTS];
    logic [NUM_TEMP_MARKS-1:0]  r_tmp_valid;
    logic [ADDR_W-1:0]      r_tmp_addr [NUM_TEMP_MARKS];
    logic [ADDR_W-1:0]      r_halt_tgt;
    logic [OPCODE_W-1:0]    r_halt_opc;

    // Result register.
    logic      r_done;
    t_status   r_status;
    logic      r_halt, r_start, r_exit, r_release, r_hit, r_exited;
    t_mode     r_res_mode;

    // Next-state values.
    t_mode                      n_mode;
    logic [NUM_BREAKPOINTS-1:0] n_bp_valid;
    logic [NUM_TEMP_MARKS-1:0]  n_tmp_valid;
    t_status                    n_status;
    logic n_halt, n_start, n_exit, n_release, n_hit, n_exited;
    logic bp_wr, tmp_wr;

    // Compare results.
    logic [ADDR_W-1:0]          key;
    logic [NUM_BREAKPOINTS-1:0] bp_match;
    logic [NUM_TEMP_MARKS-1:0]  tmp_match;
    logic                       bp_any, tmp_any;
    logic [BP_IDX_W-1:0]        bp_free_idx;
    logic [TMP_IDX_W-1:0]       tmp_free_idx;
    logic                       bp_free, tmp_free;
    logic                       is_call;

    assign busy = ~i_rst_n;

    // Capture the request and configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_call_opc     <= '0;
            r_call_ind_opc <= '0;
        end else begin
            r_in_vld <= start && !busy;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CALL_OPCODE:     r_call_opc     <= i_cfg_wdata;
                    CFG_CALL_IND_OPCODE: r_call_ind_opc <= i_cfg_wdata;
                    default:             r_call_opc     <= r_call_opc;
                endcase
            end
        end
        if (start && !busy) begin
            r_cmd  <= i_cmd;
            r_addr <= i_address;
            r_opc  <= i_opcode;
        end
    end

    // Step over looks up the address after the halted instruction.
    assign key = (r_cmd == CMD_STEP_OVER) ? r_halt_tgt : r_addr;

    // Match against both tables in parallel.
    always_comb begin
        for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
            bp_match[i] = r_bp_valid[i] && (r_bp_addr[i] == key);
        end
        for (int j = 0; j < NUM_TEMP_MARKS; j++) begin
            tmp_match[j] = r_tmp_valid[j] && (r_tmp_addr[j] == key);
        end
    end

    assign bp_any  = |bp_match;
    assign tmp_any = |tmp_match;
    assign bp_free  = ~&r_bp_valid;
    assign tmp_free = ~&r_tmp_valid;
    assign is_call = (r_halt_opc == r_call_opc) || (r_halt_opc == r_call_ind_opc);

    // Lowest free slot in each table.
    always_comb begin
        bp_free_idx = '0;
        for (int i = NUM_BREAKPOINTS - 1; i >= 0; i--) begin
            if (!r_bp_valid[i]) begin
                bp_free_idx = BP_IDX_W'(i);
            end
        end
        tmp_free_idx = '0;
        for (int j = NUM_TEMP_MARKS - 1; j >= 0; j--) begin
            if (!r_tmp_valid[j]) begin
                tmp_free_idx = TMP_IDX_W'(j);
            end
        end
    end

    // Command decode and state update.
    always_comb begin
        n_mode      = r_mode;
        n_bp_valid  = r_bp_valid;
        n_tmp_valid = r_tmp_valid;
        n_status    = ST_OK;
        n_halt      = 1'b0;
        n_start     = 1'b0;
        n_exit      = 1'b0;
        n_release   = 1'b0;
        n_hit       = 1'b0;
        n_exited    = 1'b0;
        bp_wr       = 1'b0;
        tmp_wr      = 1'b0;

        unique case (r_cmd) inside
            CMD_RUN: begin
                if (r_mode != MODE_IDLE) begin
                    n_status = ST_NOT_READY;
                    n_mode   = MODE_IDLE;
                end else begin
                    n_mode  = MODE_STARTED;
                    n_start = 1'b1;
                end
            end
            CMD_SINGLE_STEP, CMD_CONTINUE: begin
                if (r_mode != MODE_WAITING) begin
                    n_status = ST_NOT_READY;
                end else begin
                    n_mode    = (r_cmd == CMD_SINGLE_STEP) ? MODE_SINGLE : MODE_RUNNING;
                    n_release = 1'b1;
                end
            end
            CMD_STEP_OVER: begin
                if (r_mode != MODE_WAITING) begin
                    n_status = ST_NOT_READY;
                end else if (is_call) begin
                    // Plant a temporary mark after the call and let it run.
                    if (!(bp_any || bp_free) || !(tmp_any || tmp_free)) begin
                        n_status = ST_FULL;
                    end else begin
                        if (!bp_any) begin
                            n_bp_valid[bp_free_idx] = 1'b1;
                            bp_wr = 1'b1;
                        end
                        if (!tmp_any) begin
                            n_tmp_valid[tmp_free_idx] = 1'b1;
                            tmp_wr = 1'b1;
                        end
                        n_mode    = MODE_RUNNING;
                        n_release = 1'b1;
                    end
                end else begin
                    n_mode    = MODE_SINGLE;
                    n_release = 1'b1;
                end
            end
            CMD_STOP: begin
                n_exit    = 1'b1;
                n_release = 1'b1;
            end
            CMD_ADD_BP: begin
                if (!bp_any) begin
                    if (bp_free) begin
                        n_bp_valid[bp_free_idx] = 1'b1;
                        bp_wr = 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
            end
            CMD_REMOVE_BP: begin
                n_bp_valid = r_bp_valid & ~bp_match;
            end
            CMD_TOGGLE_BP: begin
                if (bp_any) begin
                    n_bp_valid = r_bp_valid & ~bp_match;
                end else if (bp_free) begin
                    n_bp_valid[bp_free_idx] = 1'b1;
                    bp_wr = 1'b1;
                end else begin
                    n_status = ST_FULL;
                end
            end
            CMD_INTERCEPT: begin
                if (r_mode == MODE_STARTED || r_mode == MODE_SINGLE) begin
                    n_halt = 1'b1;
                end else if (r_mode == MODE_RUNNING && bp_any) begin
                    n_hit  = 1'b1;
                    n_halt = 1'b1;
                    // A temporary mark is consumed by its hit.
                    if (tmp_any) begin
                        n_bp_valid  = r_bp_valid & ~bp_match;
                        n_tmp_valid = r_tmp_valid & ~tmp_match;
                    end
                end
                if (n_halt) begin
                    n_mode = MODE_WAITING;
                end
            end
            CMD_PROCESS_EXIT: begin
                n_mode   = MODE_IDLE;
                n_exited = 1'b1;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_bp_valid  <= '0;
            r_tmp_valid <= '0;
            r_halt_tgt  <= INSTR_LEN;
            r_halt_opc  <= '0;
        end else if (r_in_vld) begin
            r_mode      <= n_mode;
            r_bp_valid  <= n_bp_valid;
            r_tmp_valid <= n_tmp_valid;
            if (n_halt) begin
                r_halt_tgt <= r_addr + INSTR_LEN;
                r_halt_opc <= r_opc;
            end
        end
    end

    // Address tables.
    always_ff @(posedge i_clk) begin
        if (r_in_vld && bp_wr) begin
            r_bp_addr[bp_free_idx] <= key;
        end
        if (r_in_vld && tmp_wr) begin
            r_tmp_addr[tmp_free_idx] <= key;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
        if (r_in_vld) begin
            r_status   <= n_status;
            r_halt     <= n_halt;
            r_start    <= n_start;
            r_exit     <= n_exit;
            r_release  <= n_release;
            r_hit      <= n_hit;
            r_res_mode <= n_mode;
            r_exited   <= n_exited;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_halt           = r_halt;
    assign o_start_machine  = r_start;
    assign o_exit_request   = r_exit;
    assign o_release_res    = r_release;
    assign o_breakpoint_hit = r_hit;
    assign o_debug_mode     = r_res_mode;
    assign o_process_exited = r_exited;

endmodule

// File: rtl/dbsu_checker.sv
`timescale 1ns / 1ps
module dbsu_checker
    import dbsu_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic [1:0]          o_status,
    input logic                o_halt,
    input logic                o_start_machine,
    input logic                o_breakpoint_hit,
    input logic [2:0]          o_debug_mode
);

    // Every accepted request yields exactly one result, through the input and result registers.
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted request produced no result");

    a_res_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without a matching request");

    // A halt always leaves the debugger waiting for a command.
    a_halt_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_halt) |-> (o_debug_mode == MODE_WAITING))
        else $error("halt reported outside the waiting mode");

    // A breakpoint hit always halts.
    a_hit_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_breakpoint_hit) |-> o_halt)
        else $error("breakpoint hit without halt");

    // An accepted run starts the machine cleanly.
    a_start_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_start_machine) |->
            (o_debug_mode == MODE_STARTED && o_status == ST_OK))
        else $error("machine start with wrong mode or status");

endmodule

bind debug_breakpoint_step_unit_top dbsu_checker u_dbsu_checker (.*);
